// File: hw/rtl/pmee_pkg.sv
// Shared types and constants for the metric event encoder.
// Holds the step codes, the control word layout and the handshake structs
// passed between the sequencer and the datapath. No dependencies.
package pmee_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] CMD_HEADER = 2'd0;
  localparam logic [1:0] CMD_HOST   = 2'd1;
  localparam logic [1:0] CMD_NAME   = 2'd2;

  // Longest string a header may announce.
  localparam logic [13:0] MAX_STRING_LEN = 14'd255;

  localparam logic [4:0] FIELD_TIME  = 5'd1;
  localparam logic [4:0] FIELD_NAME  = 5'd3;
  localparam logic [4:0] FIELD_HOST  = 5'd4;
  localparam logic [4:0] FIELD_OUTER = 5'd6;
  localparam logic [4:0] FIELD_VALUE = 5'd13;
  localparam logic [2:0] WT_VARINT   = 3'd0;
  localparam logic [2:0] WT_BYTES    = 3'd2;

  localparam logic [7:0] TAG_OUTER = {FIELD_OUTER, WT_BYTES};
  localparam logic [7:0] TAG_TIME  = {FIELD_TIME, WT_VARINT};
  localparam logic [7:0] TAG_HOST  = {FIELD_HOST, WT_BYTES};
  localparam logic [7:0] TAG_NAME  = {FIELD_NAME, WT_BYTES};
  localparam logic [7:0] TAG_VALUE = {FIELD_VALUE, WT_VARINT};

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_HOST,
    PH_NAME
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OUTER_TAG,
    ST_BODY_VAR,
    ST_TIME_TAG,
    ST_TIME_VAR,
    ST_HOST_TAG,
    ST_HOST_LEN,
    ST_HOST_BYTE,
    ST_NAME_TAG,
    ST_NAME_LEN,
    ST_NAME_BYTE,
    ST_VALUE_TAG,
    ST_VALUE_VAR,
    ST_ERROR
  } step_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_TAG,
    EM_VAR,
    EM_DATA,
    EM_ERR
  } emit_t;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_BODY,
    LD_TIME,
    LD_HOST,
    LD_NAME,
    LD_VALUE
  } load_t;

  typedef enum logic [2:0] {
    BR_SEQ,        // go to target
    BR_VLOOP,      // repeat until last varint byte, then target
    BR_VLOOP_CNT,  // after last varint byte: empty string -> target, else idle
    BR_VLOOP_RET,  // after last varint byte: idle
    BR_BYTE,       // last string byte -> target, else idle
    BR_RET,        // idle
    BR_DISPATCH    // decode the next input transaction
  } branch_t;

  typedef struct packed {
    emit_t      emit;
    logic [7:0] tag;
    load_t      load;
    branch_t    branch;
    step_t      target;
    phase_t     phase;     // phase taken when a varint step returns to idle
    logic       mark_end;  // last varint byte closes the packet
  } ucode_t;

  typedef struct packed {
    ucode_t cw;
    logic   go;         // current step emits a byte this cycle
    logic   hdr_take;   // capture header fields
    logic   byte_take;  // capture a string byte
  } ctl_t;

  typedef struct packed {
    logic vlast;     // varint register holds its final group
    logic cnt_zero;
    logic cnt_one;
    logic out_go;    // output register can take a byte
  } sts_t;

endpackage

// File: hw/rtl/pmee_seq.sv
// Microcode sequencer of the metric event encoder: step counter, control
// store, branch logic and packet phase. Depends on pmee_pkg.
module pmee_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        cmd,
  input  logic [7:0]        host_length,
  input  logic [7:0]        service_length,
  input  pmee_pkg::sts_t    sts,
  output pmee_pkg::ctl_t    ctl
);
  import pmee_pkg::*;

  step_t  pc_r, pc_nxt;
  phase_t phase_r, phase_nxt;
  ucode_t cw;
  step_t  disp_step;
  logic   lens_ok;

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    w = '{emit: EM_NONE, tag: 8'h00, load: LD_NONE, branch: BR_DISPATCH,
          target: ST_IDLE, phase: PH_HEADER, mark_end: 1'b0};
    case (s)
      ST_OUTER_TAG: begin
        w.emit = EM_TAG; w.tag = TAG_OUTER; w.load = LD_BODY;
        w.branch = BR_SEQ; w.target = ST_BODY_VAR;
      end
      ST_BODY_VAR: begin
        w.emit = EM_VAR; w.branch = BR_VLOOP; w.target = ST_TIME_TAG;
      end
      ST_TIME_TAG: begin
        w.emit = EM_TAG; w.tag = TAG_TIME; w.load = LD_TIME;
        w.branch = BR_SEQ; w.target = ST_TIME_VAR;
      end
      ST_TIME_VAR: begin
        w.emit = EM_VAR; w.branch = BR_VLOOP; w.target = ST_HOST_TAG;
      end
      ST_HOST_TAG: begin
        w.emit = EM_TAG; w.tag = TAG_HOST; w.load = LD_HOST;
        w.branch = BR_SEQ; w.target = ST_HOST_LEN;
      end
      ST_HOST_LEN: begin
        w.emit = EM_VAR; w.branch = BR_VLOOP_CNT; w.target = ST_NAME_TAG;
        w.phase = PH_HOST;
      end
      ST_HOST_BYTE: begin
        w.emit = EM_DATA; w.branch = BR_BYTE; w.target = ST_NAME_TAG;
      end
      ST_NAME_TAG: begin
        w.emit = EM_TAG; w.tag = TAG_NAME; w.load = LD_NAME;
        w.branch = BR_SEQ; w.target = ST_NAME_LEN;
      end
      ST_NAME_LEN: begin
        w.emit = EM_VAR; w.branch = BR_VLOOP_CNT; w.target = ST_VALUE_TAG;
        w.phase = PH_NAME;
      end
      ST_NAME_BYTE: begin
        w.emit = EM_DATA; w.branch = BR_BYTE; w.target = ST_VALUE_TAG;
      end
      ST_VALUE_TAG: begin
        w.emit = EM_TAG; w.tag = TAG_VALUE; w.load = LD_VALUE;
        w.branch = BR_SEQ; w.target = ST_VALUE_VAR;
      end
      ST_VALUE_VAR: begin
        w.emit = EM_VAR; w.branch = BR_VLOOP_RET; w.phase = PH_HEADER;
        w.mark_end = 1'b1;
      end
      ST_ERROR: begin
        w.emit = EM_ERR; w.branch = BR_RET;
      end
      default: begin
        w.branch = BR_DISPATCH;
      end
    endcase
    return w;
  endfunction

  assign cw        = ucode_rom(pc_r);
  assign in_tready = (pc_r == ST_IDLE);
  assign lens_ok   = ({6'd0, host_length} <= MAX_STRING_LEN) &&
                     ({6'd0, service_length} <= MAX_STRING_LEN);

  // Decode of an incoming transaction against the current phase.
  always_comb begin
    disp_step = ST_ERROR;
    case (cmd)
      CMD_HEADER: if (phase_r == PH_HEADER && lens_ok) disp_step = ST_OUTER_TAG;
      CMD_HOST:   if (phase_r == PH_HOST) disp_step = ST_HOST_BYTE;
      CMD_NAME:   if (phase_r == PH_NAME) disp_step = ST_NAME_BYTE;
      default:    disp_step = ST_ERROR;
    endcase
  end

  // Next step and phase.
  always_comb begin
    pc_nxt    = pc_r;
    phase_nxt = phase_r;
    if (cw.branch == BR_DISPATCH) begin
      if (in_tvalid) begin
        pc_nxt = disp_step;
      end
    end else if (sts.out_go) begin
      case (cw.branch)
        BR_SEQ: begin
          pc_nxt = cw.target;
        end
        BR_VLOOP: begin
          if (sts.vlast) pc_nxt = cw.target;
        end
        BR_VLOOP_CNT: begin
          if (sts.vlast) begin
            if (sts.cnt_zero) begin
              pc_nxt = cw.target;
            end else begin
              pc_nxt    = ST_IDLE;
              phase_nxt = cw.phase;
            end
          end
        end
        BR_VLOOP_RET: begin
          if (sts.vlast) begin
            pc_nxt    = ST_IDLE;
            phase_nxt = cw.phase;
          end
        end
        BR_BYTE: begin
          pc_nxt = sts.cnt_one ? cw.target : ST_IDLE;
        end
        default: begin
          pc_nxt = ST_IDLE;
        end
      endcase
    end
  end

  // Control outputs to the datapath.
  always_comb begin
    ctl.cw        = cw;
    ctl.go        = (cw.branch != BR_DISPATCH) && sts.out_go;
    ctl.hdr_take  = in_tvalid && in_tready && (disp_step == ST_OUTER_TAG);
    ctl.byte_take = in_tvalid && in_tready &&
                    ((disp_step == ST_HOST_BYTE) || (disp_step == ST_NAME_BYTE));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= ST_IDLE;
      phase_r <= PH_HEADER;
    end else begin
      pc_r    <= pc_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// File: hw/rtl/pmee_dpath.sv
// Datapath of the metric event encoder: header capture, body length, the
// varint shift register, string byte counter and the output byte register.
// Driven by the control word from pmee_seq; depends on pmee_pkg.
module pmee_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  pmee_pkg::ctl_t    ctl,
  output pmee_pkg::sts_t    sts,
  input  logic [63:0]       timestamp,
  input  logic [63:0]       metric_value,
  input  logic [7:0]        host_length,
  input  logic [7:0]        service_length,
  input  logic [7:0]        data_byte,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_byte,
  output logic              packet_end,
  output logic              seq_error
);
  import pmee_pkg::*;

  logic [63:0] ts_r;
  logic [63:0] zz_r;
  logic [7:0]  hl_r;
  logic [7:0]  nl_r;
  logic [7:0]  data_r;
  logic [63:0] vreg_r, vreg_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_end_r;
  logic        out_err_r;
  logic [9:0]  body;
  logic [7:0]  emit_byte;

  // Number of 7-bit groups a varint needs.
  function automatic logic [3:0] vlen(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 10; i++) begin
      if ((v >> (7 * i)) != 64'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Four tag bytes plus four varints plus both strings.
  assign body = 10'd4 + {6'd0, vlen(ts_r)} + {6'd0, vlen({56'd0, hl_r})} +
                {6'd0, vlen({56'd0, nl_r})} + {6'd0, vlen(zz_r)} +
                {2'd0, hl_r} + {2'd0, nl_r};

  assign sts.vlast    = (vreg_r[63:7] == 57'd0);
  assign sts.cnt_zero = (cnt_r == 8'd0);
  assign sts.cnt_one  = (cnt_r == 8'd1);
  assign sts.out_go   = !out_valid_r || out_tready;

  always_comb begin
    case (ctl.cw.emit)
      EM_TAG:  emit_byte = ctl.cw.tag;
      EM_VAR:  emit_byte = {!sts.vlast, vreg_r[6:0]};
      EM_DATA: emit_byte = data_r;
      default: emit_byte = 8'h00;
    endcase
  end

  always_comb begin
    vreg_nxt = vreg_r;
    cnt_nxt  = cnt_r;
    if (ctl.go) begin
      case (ctl.cw.load)
        LD_BODY:  vreg_nxt = {54'd0, body};
        LD_TIME:  vreg_nxt = ts_r;
        LD_HOST: begin
          vreg_nxt = {56'd0, hl_r};
          cnt_nxt  = hl_r;
        end
        LD_NAME: begin
          vreg_nxt = {56'd0, nl_r};
          cnt_nxt  = nl_r;
        end
        LD_VALUE: vreg_nxt = zz_r;
        default: begin
          if (ctl.cw.emit == EM_VAR) vreg_nxt = vreg_r >> 7;
        end
      endcase
      if (ctl.cw.emit == EM_DATA) cnt_nxt = cnt_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hdr_take) begin
      ts_r <= timestamp;
      zz_r <= {metric_value[62:0], 1'b0} ^ {64{metric_value[63]}};
      hl_r <= host_length;
      nl_r <= service_length;
    end
    if (ctl.byte_take) begin
      data_r <= data_byte;
    end
    vreg_r <= vreg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (ctl.go && ctl.cw.emit != EM_NONE) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go && ctl.cw.emit != EM_NONE) begin
      out_byte_r <= emit_byte;
      out_end_r  <= ctl.cw.mark_end && sts.vlast && (ctl.cw.emit == EM_VAR);
      out_err_r  <= (ctl.cw.emit == EM_ERR);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign packet_end = out_end_r;
  assign seq_error  = out_err_r;

endmodule

// File: hw/rtl/protobuf_metric_event_encoder.sv
// Metric event encoder: turns a header transaction followed by host and name
// bytes into one length-delimited protocol-buffer event (timestamp, host,
// name, zigzag value), one byte per output transaction, tlast on the final
// byte. A header is accepted and then its bytes leave one per cycle unless
// the output stalls: outer tag, body length, timestamp, host length, up to
// 17 bytes; with an empty host string the name tag and length follow at once
// (up to 19 bytes), and with both strings empty the whole packet leaves at
// once (up to 28 bytes). Each string byte is first accepted, then emitted;
// the last byte of a string also emits the next field's tag and length (and
// the value field after the name). A rejected transaction is accepted, then
// gives one zero byte with tuser set. The single output byte register
// sets the pace; the input is held off while a transaction's bytes are being
// sent. Depends on pmee_pkg, pmee_seq and pmee_dpath.
module protobuf_metric_event_encoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // timestamp[63:0], metric_value[127:64], host_length[135:128],
  // service_length[143:136], data_byte[151:144]
  input  logic [151:0] in_tdata,
  input  logic [1:0]   in_tuser,   // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // out_byte
  output logic         out_tlast,  // packet_end
  output logic         out_tuser   // seq_error
);
  import pmee_pkg::*;

  ctl_t ctl;
  sts_t sts;

  pmee_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .cmd            (in_tuser),
    .host_length    (in_tdata[135:128]),
    .service_length (in_tdata[143:136]),
    .sts            (sts),
    .ctl            (ctl)
  );

  pmee_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .timestamp      (in_tdata[63:0]),
    .metric_value   (in_tdata[127:64]),
    .host_length    (in_tdata[135:128]),
    .service_length (in_tdata[143:136]),
    .data_byte      (in_tdata[151:144]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_byte       (out_tdata),
    .packet_end     (out_tlast),
    .seq_error      (out_tuser)
  );

endmodule
